@@ design/bitstream_file_header_parser_defines.svh @@
// assertion macros for the bitstream file header parser checker
// depends on clk and arst_n being visible where a macro is used
`ifndef BITSTREAM_FILE_HEADER_PARSER_DEFINES_SVH
`define BITSTREAM_FILE_HEADER_PARSER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define BFHP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BFHP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/bfhp_pkg.sv @@
// shared types and constants of the bitstream file header parser
// no dependencies
package bfhp_pkg;

	localparam int unsigned PHASE_W = 4;
	localparam int unsigned KIND_W  = 4;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned HLEN_W  = 20;
	localparam int unsigned BLEN_W  = 32;
	localparam int unsigned CNT_W   = 16;
	localparam int unsigned SEC_W   = 3;
	localparam int unsigned ADDR_W  = 3;
	localparam int unsigned DATA_W  = 32;

	// parse phases
	localparam logic [PHASE_W-1:0] PH_MAGLEN_HI = 4'd0;
	localparam logic [PHASE_W-1:0] PH_MAGLEN_LO = 4'd1;
	localparam logic [PHASE_W-1:0] PH_MAGIC     = 4'd2;
	localparam logic [PHASE_W-1:0] PH_TERM      = 4'd3;
	localparam logic [PHASE_W-1:0] PH_VER_HI    = 4'd4;
	localparam logic [PHASE_W-1:0] PH_VER_LO    = 4'd5;
	localparam logic [PHASE_W-1:0] PH_KEY       = 4'd6;
	localparam logic [PHASE_W-1:0] PH_SECLEN_HI = 4'd7;
	localparam logic [PHASE_W-1:0] PH_SECLEN_LO = 4'd8;
	localparam logic [PHASE_W-1:0] PH_STRING    = 4'd9;
	localparam logic [PHASE_W-1:0] PH_BITLEN    = 4'd10;
	localparam logic [PHASE_W-1:0] PH_DONE      = 4'd11;
	localparam logic [PHASE_W-1:0] PH_ERROR     = 4'd12;

	// field kinds
	localparam logic [KIND_W-1:0] KIND_MAGLEN  = 4'd0;
	localparam logic [KIND_W-1:0] KIND_MAGIC   = 4'd1;
	localparam logic [KIND_W-1:0] KIND_TERM    = 4'd2;
	localparam logic [KIND_W-1:0] KIND_VERSION = 4'd3;
	localparam logic [KIND_W-1:0] KIND_KEY     = 4'd4;
	localparam logic [KIND_W-1:0] KIND_SECLEN  = 4'd5;
	localparam logic [KIND_W-1:0] KIND_DESIGN  = 4'd6;
	localparam logic [KIND_W-1:0] KIND_PART    = 4'd7;
	localparam logic [KIND_W-1:0] KIND_DATE    = 4'd8;
	localparam logic [KIND_W-1:0] KIND_TIME    = 4'd9;
	localparam logic [KIND_W-1:0] KIND_BITLEN  = 4'd10;
	localparam logic [KIND_W-1:0] KIND_PAYLOAD = 4'd11;
	localparam logic [KIND_W-1:0] KIND_IGNORED = 4'd12;

	// parse status
	localparam logic [STAT_W-1:0] STAT_INSIDE = 2'd0;
	localparam logic [STAT_W-1:0] STAT_DONE   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_ERROR  = 2'd2;

	localparam logic [7:0]       KEY_A        = 8'h61;
	localparam logic [SEC_W-1:0] SEC_LAST     = 3'd4;
	localparam logic [CNT_W-1:0] VERSION_WORD = 16'h0001;
	localparam logic [CNT_W-1:0] BITLEN_BYTES = 16'd4;

	// register map
	localparam logic REG_EVEN_MAGIC = 1'b0;
	localparam logic REG_ODD_MAGIC  = 1'b1;
	localparam logic [7:0] EVEN_MAGIC_RST = 8'h0F;
	localparam logic [7:0] ODD_MAGIC_RST  = 8'hF0;

	typedef struct packed {
		logic [7:0] even_magic;
		logic [7:0] odd_magic;
	} bfhp_cfg_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [7:0]        text;
		logic [STAT_W-1:0] status;
		logic [HLEN_W-1:0] hlen;
		logic [BLEN_W-1:0] blen;
	} bfhp_result_t;

endpackage

@@ design/bfhp_cfg.sv @@
// apb register file holding the even and odd magic byte patterns
// depends on bfhp_pkg
module bfhp_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [bfhp_pkg::ADDR_W-1:0] paddr,
	input  logic [bfhp_pkg::DATA_W-1:0] pwdata,
	output logic [bfhp_pkg::DATA_W-1:0] prdata,
	output logic                      pready,
	output bfhp_pkg::bfhp_cfg_t       cfg
);
	import bfhp_pkg::*;

	logic [7:0] even_q;
	logic [7:0] odd_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			even_q <= EVEN_MAGIC_RST;
			odd_q  <= ODD_MAGIC_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_EVEN_MAGIC: even_q <= pwdata[7:0];
				REG_ODD_MAGIC:  odd_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_EVEN_MAGIC: prdata = {24'd0, even_q};
			REG_ODD_MAGIC:  prdata = {24'd0, odd_q};
			default:        prdata = '0;
		endcase
	end

	assign cfg.even_magic = even_q;
	assign cfg.odd_magic  = odd_q;

endmodule

@@ design/bfhp_parser.sv @@
// header phase machine: tags one byte per step and updates counters and lengths
// depends on bfhp_pkg
module bfhp_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             data_byte,
	input  logic                   first_byte,
	input  bfhp_pkg::bfhp_cfg_t    cfg,
	output bfhp_pkg::bfhp_result_t res
);
	import bfhp_pkg::*;

	logic [PHASE_W-1:0] phase_q, ph, ph_n;
	logic [CNT_W-1:0]   fcnt_q, fc, fc_n, fc_inc;
	logic [CNT_W-1:0]   flen_q, fl, fl_n;
	logic [SEC_W-1:0]   sec_q, si, si_n;
	logic [HLEN_W-1:0]  bpos_q, bp, bp_n;
	logic [BLEN_W-1:0]  acc_q, acc, acc_n;
	logic [CNT_W-1:0]   word;
	logic [7:0]         magic_exp;
	logic [KIND_W-1:0]  kind;
	logic [7:0]         text;
	logic [STAT_W-1:0]  status;

	always_comb begin
		// a first byte restarts from a cleared state
		ph  = first_byte ? PH_MAGLEN_HI : phase_q;
		fc  = first_byte ? '0 : fcnt_q;
		fl  = first_byte ? '0 : flen_q;
		si  = first_byte ? '0 : sec_q;
		bp  = first_byte ? '0 : bpos_q;
		acc = first_byte ? '0 : acc_q;

		ph_n      = ph;
		fc_n      = fc;
		fl_n      = fl;
		si_n      = si;
		acc_n     = acc;
		kind      = KIND_IGNORED;
		text      = '0;
		word      = {acc[7:0], data_byte};
		fc_inc    = fc + 16'd1;
		magic_exp = fc[0] ? cfg.odd_magic : cfg.even_magic;
		bp_n      = (ph != PH_DONE && ph != PH_ERROR) ? bp + 20'd1 : bp;

		unique case (ph)
			PH_MAGLEN_HI: begin
				kind  = KIND_MAGLEN;
				acc_n = {24'd0, data_byte};
				ph_n  = PH_MAGLEN_LO;
			end
			PH_MAGLEN_LO: begin
				kind = KIND_MAGLEN;
				if (word == '0) begin
					ph_n = PH_ERROR;
				end else begin
					fl_n = word - 16'd1;
					fc_n = '0;
					ph_n = (word == 16'd1) ? PH_TERM : PH_MAGIC;
				end
			end
			PH_MAGIC: begin
				kind = KIND_MAGIC;
				if (data_byte != magic_exp) begin
					ph_n = PH_ERROR;
				end else begin
					fc_n = fc_inc;
					if (fc_inc == fl)
						ph_n = PH_TERM;
				end
			end
			PH_TERM: begin
				kind = KIND_TERM;
				ph_n = PH_VER_HI;
			end
			PH_VER_HI: begin
				kind  = KIND_VERSION;
				acc_n = {24'd0, data_byte};
				ph_n  = PH_VER_LO;
			end
			PH_VER_LO: begin
				kind = KIND_VERSION;
				if (word != VERSION_WORD) begin
					ph_n = PH_ERROR;
				end else begin
					si_n = '0;
					ph_n = PH_KEY;
				end
			end
			PH_KEY: begin
				kind = KIND_KEY;
				if (si > SEC_LAST || data_byte != KEY_A + {5'd0, si}) begin
					ph_n = PH_ERROR;
				end else if (si == SEC_LAST) begin
					fc_n  = '0;
					acc_n = '0;
					ph_n  = PH_BITLEN;
				end else begin
					ph_n = PH_SECLEN_HI;
				end
			end
			PH_SECLEN_HI: begin
				kind  = KIND_SECLEN;
				acc_n = {24'd0, data_byte};
				ph_n  = PH_SECLEN_LO;
			end
			PH_SECLEN_LO: begin
				kind = KIND_SECLEN;
				fl_n = word;
				fc_n = '0;
				if (word == '0) begin
					si_n = si + 3'd1;
					ph_n = PH_KEY;
				end else begin
					ph_n = PH_STRING;
				end
			end
			PH_STRING: begin
				kind = KIND_DESIGN + {2'd0, si[1:0]};
				text = data_byte;
				fc_n = fc_inc;
				if (fc_inc == fl) begin
					si_n = si + 3'd1;
					ph_n = PH_KEY;
				end
			end
			PH_BITLEN: begin
				kind  = KIND_BITLEN;
				acc_n = {acc[23:0], data_byte};
				fc_n  = fc_inc;
				if (fc_inc >= BITLEN_BYTES)
					ph_n = PH_DONE;
			end
			PH_DONE: begin
				kind = KIND_PAYLOAD;
			end
			default: begin
				kind = KIND_IGNORED;
				ph_n = PH_ERROR;
			end
		endcase

		if (ph_n == PH_DONE)
			status = STAT_DONE;
		else if (ph_n == PH_ERROR)
			status = STAT_ERROR;
		else
			status = STAT_INSIDE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGLEN_HI;
			fcnt_q  <= '0;
			flen_q  <= '0;
			sec_q   <= '0;
			bpos_q  <= '0;
			acc_q   <= '0;
		end else if (step) begin
			phase_q <= ph_n;
			fcnt_q  <= fc_n;
			flen_q  <= fl_n;
			sec_q   <= si_n;
			bpos_q  <= bp_n;
			acc_q   <= acc_n;
		end
	end

	assign res.kind   = kind;
	assign res.text   = text;
	assign res.status = status;
	assign res.hlen   = bp_n;
	assign res.blen   = (status == STAT_DONE) ? acc_n : '0;

endmodule

@@ design/bitstream_file_header_parser.sv @@
// top level of the bitstream file header parser: input register, parser, result register
// depends on bfhp_pkg, bfhp_cfg and bfhp_parser
//
//   channel  signals                         payload
//   input    in_valid / in_ready             data_byte, first_byte
//   output   out_valid / out_ready           field_kind, text_byte, parse_status,
//                                            header_length, bitstream_length
//   config   psel penable pwrite pready      paddr, pwdata, prdata
//
// one byte per cycle sustained while out_ready stays high; each accepted byte is held in the input register
// and leaves through the result register, which presents its result
// the phase machine and its counters update when a byte moves into the result register
// a stalled output holds the result and stops the input register from draining
// reset restores both magic patterns and parses from the magic length high byte
module bitstream_file_header_parser (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [bfhp_pkg::ADDR_W-1:0]       paddr,
	input  logic [bfhp_pkg::DATA_W-1:0]       pwdata,
	output logic [bfhp_pkg::DATA_W-1:0]       prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        data_byte,
	input  logic                              first_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [bfhp_pkg::KIND_W-1:0]       field_kind,
	output logic [7:0]                        text_byte,
	output logic [bfhp_pkg::STAT_W-1:0]       parse_status,
	output logic [bfhp_pkg::HLEN_W-1:0]       header_length,
	output logic [bfhp_pkg::BLEN_W-1:0]       bitstream_length
);
	import bfhp_pkg::*;

	bfhp_cfg_t    cfg;
	bfhp_result_t res;
	bfhp_result_t res_s2;
	logic         valid_s1;
	logic         valid_s2;
	logic [7:0]   data_s1;
	logic         first_s1;
	logic         advance;

	bfhp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign advance  = valid_s1 & (~valid_s2 | out_ready);
	assign in_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid & in_ready) begin
			data_s1  <= data_byte;
			first_s1 <= first_byte;
		end
		if (advance)
			res_s2 <= res;
	end

	bfhp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.data_byte  (data_s1),
		.first_byte (first_s1),
		.cfg        (cfg),
		.res        (res)
	);

	assign out_valid        = valid_s2;
	assign field_kind       = res_s2.kind;
	assign text_byte        = res_s2.text;
	assign parse_status     = res_s2.status;
	assign header_length    = res_s2.hlen;
	assign bitstream_length = res_s2.blen;

endmodule

@@ design/bfhp_checker.sv @@
// port-level checks for the bitstream file header parser, bound to the top level
// depends on bfhp_pkg and bitstream_file_header_parser_defines.svh
`include "bitstream_file_header_parser_defines.svh"

module bfhp_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [bfhp_pkg::KIND_W-1:0]  field_kind,
	input logic [7:0]                   text_byte,
	input logic [bfhp_pkg::STAT_W-1:0]  parse_status,
	input logic [bfhp_pkg::BLEN_W-1:0]  bitstream_length
);
	import bfhp_pkg::*;

	`BFHP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(field_kind) && $stable(parse_status), "result changed while stalled")
	`BFHP_ASSERT_SAME(a_blen_zero, out_valid && parse_status != STAT_DONE, bitstream_length == '0, "bitstream length shown before completion")
	`BFHP_ASSERT_SAME(a_text_zero, out_valid && field_kind != KIND_DESIGN && field_kind != KIND_PART && field_kind != KIND_DATE && field_kind != KIND_TIME, text_byte == '0, "text byte on a non-string field")
	`BFHP_ASSERT_SAME(a_ignored_err, out_valid && field_kind == KIND_IGNORED, parse_status == STAT_ERROR, "ignored byte without error status")
	`BFHP_ASSERT_SAME(a_payload_done, out_valid && field_kind == KIND_PAYLOAD, parse_status == STAT_DONE, "payload byte without complete status")

endmodule

bind bitstream_file_header_parser bfhp_checker u_bfhp_checker (.*);

@@ tb/sv/bitstream_file_header_parser_tb.sv @@
// testbench of the bitstream file header parser: directed table, then random headers
// checks every result against an in-bench parse predictor or a typed table row; depends on bfhp_pkg and the top level
// drives bytes and apb writes on falling edges, samples on rising edges
module bitstream_file_header_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bfhp_pkg::*;

	localparam int LIMIT          = 1000000;
	localparam int RAND_PER_PHASE = 270;
	localparam int N_PHASES       = 5;
	localparam int HOLD_AT        = 700;
	localparam int HOLD_CYCLES    = 500;
	localparam logic [ADDR_W-1:0] ADDR_EVEN = {REG_EVEN_MAGIC, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_ODD  = {REG_ODD_MAGIC, 2'b00};

	typedef struct {
		logic [7:0]   data;
		logic         first;
		logic         typed;
		bfhp_result_t want;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [7:0]          data_byte = '0;
	logic                first_byte = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [KIND_W-1:0]   field_kind;
	logic [7:0]          text_byte;
	logic [STAT_W-1:0]   parse_status;
	logic [HLEN_W-1:0]   header_length;
	logic [BLEN_W-1:0]   bitstream_length;

	// predictor state and its copy of the magic patterns
	logic [PHASE_W-1:0]  pr_phase = PH_MAGLEN_HI;
	logic [CNT_W-1:0]    pr_cnt = '0;
	logic [CNT_W-1:0]    pr_len = '0;
	logic [SEC_W-1:0]    pr_sec = '0;
	logic [HLEN_W-1:0]   pr_pos = '0;
	logic [BLEN_W-1:0]   pr_acc = '0;
	logic [7:0]          cfg_even = EVEN_MAGIC_RST;
	logic [7:0]          cfg_odd = ODD_MAGIC_RST;

	bfhp_result_t        field_q [$];
	stim_row_t           dir_tab [$];
	int                  err_count = 0;
	int                  cycles = 0;
	int                  rx_count = 0;
	int                  parsed_bytes = 0;
	int                  tx_gap = 0;
	int                  tx_calm = 0;
	int                  rx_calm = 0;
	logic                tx_held = 1'b0;
	int                  hdr_idx = 0;
	int                  corrupt_at = -1;

	bitstream_file_header_parser dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.data_byte        (data_byte),
		.first_byte       (first_byte),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.field_kind       (field_kind),
		.text_byte        (text_byte),
		.parse_status     (parse_status),
		.header_length    (header_length),
		.bitstream_length (bitstream_length)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic bfhp_result_t parse_byte(input logic [7:0] b, input logic f);
		bfhp_result_t r;
		logic [CNT_W-1:0] w;
		r = '0;
		r.kind = KIND_IGNORED;
		if (f) begin
			pr_phase = PH_MAGLEN_HI;
			pr_cnt = '0;
			pr_len = '0;
			pr_sec = '0;
			pr_pos = '0;
			pr_acc = '0;
		end
		if (pr_phase != PH_DONE && pr_phase != PH_ERROR)
			pr_pos = pr_pos + 20'd1;
		case (pr_phase)
			PH_MAGLEN_HI: begin
				r.kind = KIND_MAGLEN;
				pr_acc = {24'd0, b};
				pr_phase = PH_MAGLEN_LO;
			end
			PH_MAGLEN_LO: begin
				r.kind = KIND_MAGLEN;
				w = {pr_acc[7:0], b};
				if (w == '0) begin
					pr_phase = PH_ERROR;
				end else begin
					pr_len = w - 16'd1;
					pr_cnt = '0;
					pr_phase = (pr_len == '0) ? PH_TERM : PH_MAGIC;
				end
			end
			PH_MAGIC: begin
				r.kind = KIND_MAGIC;
				if (b != (pr_cnt[0] ? cfg_odd : cfg_even)) begin
					pr_phase = PH_ERROR;
				end else begin
					pr_cnt = pr_cnt + 16'd1;
					if (pr_cnt == pr_len)
						pr_phase = PH_TERM;
				end
			end
			PH_TERM: begin
				r.kind = KIND_TERM;
				pr_phase = PH_VER_HI;
			end
			PH_VER_HI: begin
				r.kind = KIND_VERSION;
				pr_acc = {24'd0, b};
				pr_phase = PH_VER_LO;
			end
			PH_VER_LO: begin
				r.kind = KIND_VERSION;
				w = {pr_acc[7:0], b};
				if (w != VERSION_WORD) begin
					pr_phase = PH_ERROR;
				end else begin
					pr_sec = '0;
					pr_phase = PH_KEY;
				end
			end
			PH_KEY: begin
				r.kind = KIND_KEY;
				if (pr_sec > SEC_LAST || b != KEY_A + 8'(pr_sec)) begin
					pr_phase = PH_ERROR;
				end else if (pr_sec == SEC_LAST) begin
					pr_cnt = '0;
					pr_acc = '0;
					pr_phase = PH_BITLEN;
				end else begin
					pr_phase = PH_SECLEN_HI;
				end
			end
			PH_SECLEN_HI: begin
				r.kind = KIND_SECLEN;
				pr_acc = {24'd0, b};
				pr_phase = PH_SECLEN_LO;
			end
			PH_SECLEN_LO: begin
				r.kind = KIND_SECLEN;
				pr_len = {pr_acc[7:0], b};
				pr_cnt = '0;
				if (pr_len == '0) begin
					pr_sec = pr_sec + 3'd1;
					pr_phase = PH_KEY;
				end else begin
					pr_phase = PH_STRING;
				end
			end
			PH_STRING: begin
				r.kind = KIND_DESIGN + KIND_W'(pr_sec[1:0]);
				r.text = b;
				pr_cnt = pr_cnt + 16'd1;
				if (pr_cnt == pr_len) begin
					pr_sec = pr_sec + 3'd1;
					pr_phase = PH_KEY;
				end
			end
			PH_BITLEN: begin
				r.kind = KIND_BITLEN;
				pr_acc = {pr_acc[23:0], b};
				pr_cnt = pr_cnt + 16'd1;
				if (pr_cnt >= BITLEN_BYTES)
					pr_phase = PH_DONE;
			end
			PH_DONE: begin
				r.kind = KIND_PAYLOAD;
			end
			default: begin
				r.kind = KIND_IGNORED;
				pr_phase = PH_ERROR;
			end
		endcase
		if (pr_phase == PH_DONE)
			r.status = STAT_DONE;
		else if (pr_phase == PH_ERROR)
			r.status = STAT_ERROR;
		else
			r.status = STAT_INSIDE;
		r.hlen = pr_pos;
		r.blen = (r.status == STAT_DONE) ? pr_acc : '0;
		return r;
	endfunction

	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 49) == 0) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		return $urandom_range(0, 14);
	endfunction

	function automatic stim_row_t row(input logic [7:0] d, input logic f);
		stim_row_t s;
		s.data = d;
		s.first = f;
		s.typed = 1'b0;
		s.want = '0;
		return s;
	endfunction

	function automatic stim_row_t trow(input logic [7:0] d, input logic f,
			input logic [KIND_W-1:0] k, input logic [STAT_W-1:0] st,
			input logic [HLEN_W-1:0] h, input logic [BLEN_W-1:0] bl);
		stim_row_t s;
		s.data = d;
		s.first = f;
		s.typed = 1'b1;
		s.want = '{kind: k, text: 8'h00, status: st, hlen: h, blen: bl};
		return s;
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		err_count++;
		$display("mismatch %s: got %0h expected %0h (cycle %0d)", what, got, want, cycles);
	endtask

	// entered and left at a falling edge
	task automatic send_item(input logic [7:0] d, input logic f, input logic typed,
			input bfhp_result_t want);
		bfhp_result_t pred;
		repeat (tx_gap) @(negedge clk);
		in_valid <= 1'b1;
		data_byte <= d;
		first_byte <= f;
		do @(posedge clk); while (!in_ready);
		pred = parse_byte(d, f);
		field_q.push_back(typed ? want : pred);
		if (pred.kind != KIND_IGNORED)
			parsed_bytes++;
		@(negedge clk);
		tx_gap = draw_gap(tx_calm);
		tx_held = (tx_gap == 0);
		if (!tx_held)
			in_valid <= 1'b0;
	endtask

	// header bytes, with an optional damaged byte or restart at corrupt_at
	task automatic emit(input logic [7:0] d, input logic f);
		logic [7:0] dd;
		logic ff;
		dd = d;
		ff = f;
		if (hdr_idx == corrupt_at) begin
			if ($urandom_range(0, 1))
				dd = 8'($urandom);
			else
				ff = 1'b1;
		end
		hdr_idx++;
		send_item(dd, ff, 1'b0, '0);
	endtask

	task automatic gen_header();
		int mlen;
		int slen;
		logic [31:0] blen;
		corrupt_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 40) : -1;
		hdr_idx = 0;
		case ($urandom_range(0, 59))
			0: mlen = 0;
			1: mlen = $urandom_range(200, 400);
			default: mlen = $urandom_range(1, 9);
		endcase
		emit(mlen[15:8], 1'b1);
		emit(mlen[7:0], 1'b0);
		for (int k = 0; k < mlen - 1; k++)
			emit(k[0] ? cfg_odd : cfg_even, 1'b0);
		emit(8'($urandom), 1'b0);
		emit(VERSION_WORD[15:8], 1'b0);
		emit(VERSION_WORD[7:0], 1'b0);
		for (int s = 0; s < SEC_LAST; s++) begin
			emit(KEY_A + 8'(s), 1'b0);
			slen = ($urandom_range(0, 39) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 6);
			emit(slen[15:8], 1'b0);
			emit(slen[7:0], 1'b0);
			for (int j = 0; j < slen; j++)
				emit(8'($urandom), 1'b0);
		end
		emit(KEY_A + 8'(SEC_LAST), 1'b0);
		blen = $urandom;
		emit(blen[31:24], 1'b0);
		emit(blen[23:16], 1'b0);
		emit(blen[15:8], 1'b0);
		emit(blen[7:0], 1'b0);
		repeat ($urandom_range(0, 6))
			emit(8'($urandom), 1'b0);
	endtask

	task automatic drain();
		if (tx_held) begin
			in_valid <= 1'b0;
			tx_held = 1'b0;
		end
		while (field_q.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apb_write(input logic [ADDR_W-1:0] a, input logic [7:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= {24'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apb_check(input logic [ADDR_W-1:0] a, input logic [7:0] v);
		logic [DATA_W-1:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= a;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		if (got[7:0] !== v)
			note_mismatch("register readback", {24'd0, got[7:0]}, {24'd0, v});
	endtask

	task automatic set_magic(input logic [7:0] ev, input logic [7:0] od);
		apb_write(ADDR_EVEN, ev);
		apb_write(ADDR_ODD, od);
		cfg_even = ev;
		cfg_odd = od;
		apb_check(ADDR_EVEN, ev);
		apb_check(ADDR_ODD, od);
	endtask

	// result side
	initial begin
		bfhp_result_t want;
		int stall;
		wait (arst_n === 1'b1);
		@(negedge clk);
		out_ready <= 1'b1;
		forever begin
			do @(posedge clk); while (!(out_valid && out_ready));
			if (field_q.size() == 0) begin
				note_mismatch("result with nothing expected", {28'd0, field_kind}, 32'd0);
			end else begin
				want = field_q.pop_front();
				if (field_kind !== want.kind)
					note_mismatch("field_kind", {28'd0, field_kind}, {28'd0, want.kind});
				if (text_byte !== want.text)
					note_mismatch("text_byte", {24'd0, text_byte}, {24'd0, want.text});
				if (parse_status !== want.status)
					note_mismatch("parse_status", {30'd0, parse_status}, {30'd0, want.status});
				if (header_length !== want.hlen)
					note_mismatch("header_length", {12'd0, header_length}, {12'd0, want.hlen});
				if (bitstream_length !== want.blen)
					note_mismatch("bitstream_length", bitstream_length, want.blen);
			end
			rx_count++;
			@(negedge clk);
			stall = (rx_count == HOLD_AT) ? HOLD_CYCLES : draw_gap(rx_calm);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	// byte side
	initial begin
		logic [7:0] ev;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		dir_tab = '{
			trow(8'h00, 1'b0, KIND_MAGLEN, STAT_INSIDE, 20'd1, 32'd0),
			trow(8'h00, 1'b0, KIND_MAGLEN, STAT_ERROR, 20'd2, 32'd0),
			trow(8'hFF, 1'b0, KIND_IGNORED, STAT_ERROR, 20'd2, 32'd0),
			row(8'h00, 1'b1), row(8'h03, 1'b0), row(EVEN_MAGIC_RST, 1'b0),
			trow(8'h0E, 1'b0, KIND_MAGIC, STAT_ERROR, 20'd4, 32'd0),
			row(8'h00, 1'b1), row(8'h01, 1'b0), row(8'hFF, 1'b0),
			row(VERSION_WORD[15:8], 1'b0), row(VERSION_WORD[7:0], 1'b0),
			row(KEY_A, 1'b0), row(8'h00, 1'b0), row(8'h01, 1'b0), row(8'hFF, 1'b0),
			row(KEY_A + 8'd1, 1'b0), row(8'h00, 1'b0), row(8'h00, 1'b0),
			row(KEY_A + 8'd2, 1'b0), row(8'h00, 1'b0), row(8'h01, 1'b0), row(8'h80, 1'b0),
			row(KEY_A + 8'd3, 1'b0), row(8'h00, 1'b0), row(8'h00, 1'b0),
			row(KEY_A + 8'(SEC_LAST), 1'b0), row(8'hFF, 1'b0), row(8'hFF, 1'b0),
			row(8'hFF, 1'b0),
			trow(8'hFF, 1'b0, KIND_BITLEN, STAT_DONE, 20'd24, 32'hFFFF_FFFF),
			trow(8'h00, 1'b0, KIND_PAYLOAD, STAT_DONE, 20'd24, 32'hFFFF_FFFF),
			trow(KEY_A, 1'b1, KIND_MAGLEN, STAT_INSIDE, 20'd1, 32'd0)
		};
		foreach (dir_tab[i])
			send_item(dir_tab[i].data, dir_tab[i].first, dir_tab[i].typed, dir_tab[i].want);

		for (int p = 0; p < N_PHASES; p++) begin
			drain();
			case (p)
				0: ;
				1: set_magic(8'h00, 8'hFF);
				2: set_magic(8'hFF, 8'h00);
				3: set_magic(8'($urandom), 8'($urandom));
				default: begin
					ev = 8'($urandom);
					set_magic(ev, ev);
				end
			endcase
			parsed_bytes = 0;
			while (parsed_bytes < RAND_PER_PHASE) begin
				if ($urandom_range(0, 9) == 0) begin
					repeat ($urandom_range(1, 8))
						send_item(8'($urandom), $urandom_range(0, 3) == 0, 1'b0, '0);
				end else begin
					gen_header();
				end
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
